>>> hw/rtl/sliding_median_filter_3axis_macros.svh
// Assertion helpers shared by the RTL; every check is clocked on clk
// and held off while rst_n is low.
`ifndef SLIDING_MEDIAN_FILTER_3AXIS_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_3AXIS_MACROS_SVH

// Same-cycle implication.
`define SMF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smf same-cycle check failed");

// Next-cycle implication.
`define SMF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smf next-cycle check failed");

`endif

>>> hw/rtl/smf_pkg.sv
`default_nettype none

package smf_pkg;

  localparam int AXES        = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int WIN_SIZE_W  = 6;

  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET = 6'd5;

  // Register index taken from paddr above the byte offset
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift;   // take the neighbor's history sample
    logic load;    // copy history into the ring, clear rank counters
    logic count;   // compare against the passing ring value, then rotate
    logic mark;    // replace ring valid bits with the median hit flags
    logic rotate;  // rotate the ring toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/smf_if.sv
`default_nettype none

interface smf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

interface smf_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median_x;
  logic signed [SAMPLE_BITS-1:0] median_y;
  logic signed [SAMPLE_BITS-1:0] median_z;

  modport source (output valid, output median_x, output median_y, output median_z,
                  input ready);
  modport sink (input valid, input median_x, input median_y, input median_z,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/smf_cell.sv
`default_nettype none

module smf_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 6,
  parameter int CELL_IDX    = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  smf_pkg::cell_ctl_t           ctl,
  input  wire logic [CNT_W-1:0]        win_w,
  input  wire logic [CNT_W-1:0]        rank,
  input  wire logic signed [SAMPLE_BITS-1:0] hist_in,
  input  wire logic signed [SAMPLE_BITS-1:0] circ_in,
  input  wire logic                    circ_v_in,
  output logic signed [SAMPLE_BITS-1:0] hist_out,
  output logic signed [SAMPLE_BITS-1:0] circ_out,
  output logic                         circ_v_out
);
  import smf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] hist_r;
  logic signed [SAMPLE_BITS-1:0] circ_r;
  logic                          circ_v_r;
  logic [CNT_W-1:0]              below_r, below_nxt;
  logic [CNT_W-1:0]              nab_r, nab_nxt;
  logic                          own_en;
  logic                          hit;

  // Cell takes part only when it lies inside the current window
  assign own_en = CNT_W'(CELL_IDX) < win_w;
  assign hit    = own_en && (below_r <= rank) && (rank < nab_r);

  always_comb begin
    below_nxt = below_r + CNT_W'(circ_r < hist_r);
    nab_nxt   = nab_r + CNT_W'(circ_r <= hist_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      circ_v_r <= 1'b0;
    end else begin
      if (ctl.shift) begin
        hist_r <= hist_in;
      end
      priority if (ctl.load) begin
        circ_v_r <= own_en;
      end else if (ctl.mark) begin
        circ_v_r <= hit;
      end else if (ctl.count || ctl.rotate) begin
        circ_v_r <= circ_v_in;
      end else begin
        circ_v_r <= circ_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      circ_r  <= hist_r;
      below_r <= '0;
      nab_r   <= '0;
    end else begin
      if (ctl.count || ctl.rotate) begin
        circ_r <= circ_in;
      end
      if (ctl.count && circ_v_r) begin
        below_r <= below_nxt;
        nab_r   <= nab_nxt;
      end
    end
  end

  assign hist_out   = hist_r;
  assign circ_out   = circ_r;
  assign circ_v_out = circ_v_r;

endmodule

`default_nettype wire

>>> hw/rtl/sliding_median_filter_3axis.sv
// From input acceptance the sequencer steps through LOAD, a full ring turn in COUNT, MARK, then
// SEL until every axis has seen a median cell at cell 0, and DONE hands off to out valid. A new
//   input is taken only once the previous result has moved into the output register.
// The next input is taken while a finished result still waits in the output register.
// Reset (synchronous, rst_n low): history cleared to zero, window_size = 5, no output valid.
`default_nettype none
`include "sliding_median_filter_3axis_macros.svh"

module sliding_median_filter_3axis #(
  parameter int WINDOW_MAX  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  smf_in_if.sink                            in_ch,
  smf_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [smf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [smf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [smf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import smf_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CYC_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // One-hot sequencer
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_COUNT = 6'b000100,
    ST_MARK  = 6'b001000,
    ST_SEL   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CYC_W-1:0]              cyc_r, cyc_nxt;
  logic [AXES-1:0]               found_r, found_nxt, capture;
  logic signed [SAMPLE_BITS-1:0] med_r [AXES];
  logic signed [SAMPLE_BITS-1:0] out_med_r [AXES];
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_load;
  logic                          in_accept;
  cell_ctl_t                     ctl;

  logic [WIN_SIZE_W-1:0]         window_size_r;
  logic [WIN_SIZE_W:0]           ws_ext;
  logic [CNT_W-1:0]              win_w;
  logic [CNT_W-1:0]              rank;
  logic                          cfg_wr;
  logic [CFG_ADDR_W-3:0]         cfg_idx;

  // Cell chain wiring, one row per axis
  logic signed [SAMPLE_BITS-1:0] samp [AXES];
  logic signed [SAMPLE_BITS-1:0] hist_w [AXES][WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] circ_w [AXES][WINDOW_MAX];
  logic                          circ_v_w [AXES][WINDOW_MAX];

  // ---------------------------------------------------------------------------
  // Configuration port: single register, always ready
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_SIZE_RESET;
    end else if (cfg_wr) begin
      window_size_r <= pwdata[WIN_SIZE_W-1:0];
    end
  end

  always_comb begin
    if (cfg_idx == REG_WINDOW_SIZE) begin
      prdata = CFG_DATA_W'(window_size_r);
    end else begin
      prdata = '0;
    end
  end

  // Clamp window to 1..WINDOW_MAX; median rank is the upper middle
  assign ws_ext = {1'b0, window_size_r};
  always_comb begin
    priority if (window_size_r == '0) begin
      win_w = CNT_W'(1);
    end else if (ws_ext > (WIN_SIZE_W + 1)'(WINDOW_MAX)) begin
      win_w = CNT_W'(WINDOW_MAX);
    end else begin
      win_w = CNT_W'(ws_ext);
    end
  end
  assign rank = win_w >> 1;

  // ---------------------------------------------------------------------------
  // Cell rows. History shifts toward higher indexes on each accepted sample;
  // the ring copy rotates toward cell 0 so every cell sees every sample once.
  // ---------------------------------------------------------------------------
  assign samp[0] = in_ch.sample_x;
  assign samp[1] = in_ch.sample_y;
  assign samp[2] = in_ch.sample_z;

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] hist_src;

      if (i == 0) begin : g_head
        assign hist_src = samp[a];
      end else begin : g_body
        assign hist_src = hist_w[a][i-1];
      end

      smf_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .CELL_IDX    (i)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .win_w      (win_w),
        .rank       (rank),
        .hist_in    (hist_src),
        .circ_in    (circ_w[a][(i + 1) % WINDOW_MAX]),
        .circ_v_in  (circ_v_w[a][(i + 1) % WINDOW_MAX]),
        .hist_out   (hist_w[a][i]),
        .circ_out   (circ_w[a][i]),
        .circ_v_out (circ_v_w[a][i])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  //   IDLE : accept a transaction, shift it into the history
  //   LOAD : copy history into the ring, clear rank counters
  //   COUNT: one full ring turn; each cell counts samples below / not above
  //   MARK : ring valid bits now flag cells holding the median
  //   SEL  : rotate again; the first flagged value reaching cell 0 is the median
  //   DONE : hand off to the output register once it is free
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      capture[a] = (state_r == ST_SEL) && circ_v_w[a][0] && !found_r[a];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cyc_nxt   = cyc_r;
    found_nxt = found_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          ctl.shift = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.load  = 1'b1;
        cyc_nxt   = '0;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        ctl.count = 1'b1;
        if (cyc_r == CYC_W'(WINDOW_MAX - 1)) begin
          state_nxt = ST_MARK;
        end else begin
          cyc_nxt = CYC_W'(cyc_r + 1'b1);
        end
      end
      ST_MARK: begin
        ctl.mark  = 1'b1;
        found_nxt = '0;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        ctl.rotate = 1'b1;
        found_nxt  = found_r | capture;
        if (&found_nxt) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cyc_r   <= '0;
      found_r <= '0;
    end else begin
      state_r <= state_nxt;
      cyc_r   <= cyc_nxt;
      found_r <= found_nxt;
    end
  end

  // Hold each axis median once found
  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (capture[a]) begin
        med_r[a] <= circ_w[a][0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: decouples the result from the next transaction's work
  // ---------------------------------------------------------------------------
  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_med_r <= med_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.median_x = out_med_r[0];
  assign out_ch.median_y = out_med_r[1];
  assign out_ch.median_z = out_med_r[2];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SMF_ASSERT_NXT(a_accept_starts_load, in_ch.valid && in_ch.ready, state_r == ST_LOAD)
  `SMF_ASSERT_IMP(a_done_has_all_axes, state_r == ST_DONE, &found_r)
  `SMF_ASSERT_NXT(a_done_waits_on_stall, state_r == ST_DONE && out_valid_r && !out_ch.ready, state_r == ST_DONE && out_valid_r)
  `SMF_ASSERT_NXT(a_handoff_sets_valid, out_load, out_valid_r && state_r == ST_IDLE)

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smf_pkg::*;

  localparam int WINDOW_MAX  = 32;
  localparam int SAMPLE_BITS = 16;
  // Ring turns once to count and again, at most a full turn, to select; give a finished result room to drain.
  localparam int HOLD_OFF     = 2 * WINDOW_MAX + 8;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TOTAL_ITEMS  = 550;

  // Byte addresses: register index sits above the two offset bits.
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED    = 3'b100;

  // One value per axis: [0] x, [1] y, [2] z.
  typedef logic [2:0][SAMPLE_BITS-1:0] triple_t;

  // Tracks the per-axis history and window setting, and holds the medians
  // still owed by the block in arrival order.
  class median_scoreboard;
    logic [SAMPLE_BITS-1:0] hist [3][WINDOW_MAX];
    logic [WIN_SIZE_W-1:0]  window_size;
    triple_t                owed_medians[$];
    string                  axis_tag[3] = '{"x", "y", "z"};
    int                     n_samples;
    int                     n_medians;
    int                     n_writes;
    int                     errors;

    function new();
      window_size = WIN_SIZE_RESET;
      foreach (hist[a, i]) hist[a][i] = '0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      if (addr[CFG_ADDR_W-1:2] == REG_WINDOW_SIZE) window_size = data[WIN_SIZE_W-1:0];
    endfunction

    // Sort the newest w entries and take the one at rank w/2.
    function logic [SAMPLE_BITS-1:0] axis_median(int axis, int w);
      logic signed [SAMPLE_BITS-1:0] vals [WINDOW_MAX];
      logic signed [SAMPLE_BITS-1:0] t;
      int j;
      for (int i = 0; i < w; i++) vals[i] = hist[axis][i];
      for (int i = 1; i < w; i++) begin
        t = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > t) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = t;
      end
      return vals[w / 2];
    endfunction

    function void note_sample(triple_t s);
      triple_t m;
      int w;
      w = (window_size == 0) ? 1 : ((window_size > WINDOW_MAX) ? WINDOW_MAX : window_size);
      for (int a = 0; a < 3; a++) begin
        for (int i = WINDOW_MAX - 1; i > 0; i--) hist[a][i] = hist[a][i - 1];
        hist[a][0] = s[a];
        m[a] = axis_median(a, w);
      end
      owed_medians.push_back(m);
      n_samples++;
    endfunction

    function void check_median(triple_t got);
      triple_t want;
      if (owed_medians.size() == 0) begin
        errors++;
        $display("%0t: unexpected median x=%0d y=%0d z=%0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]));
        return;
      end
      want = owed_medians.pop_front();
      n_medians++;
      for (int a = 0; a < 3; a++) begin
        if (got[a] !== want[a]) begin
          errors++;
          $display("%0t: median_%s expected %0d, got %0d", $time, axis_tag[a],
                   $signed(want[a]), $signed(got[a]));
        end
      end
    endfunction

    function int pending();
      return owed_medians.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  smf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  smf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();

  sliding_median_filter_3axis #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  median_scoreboard sb;
  int      cycles = 0;
  bit      steady;       // when set, neither side inserts gaps
  triple_t last_sample;
  int      sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both channels at the edge: record accepted samples, check medians.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_sample({in_if.sample_z, in_if.sample_y, in_if.sample_x});
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_median({out_if.median_z, out_if.median_y, out_if.median_x});
  end

  // Mostly short gaps, a few long ones, none during steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pick one axis value: full range, tight cluster for ties, extremes, a small band
  // around zero, repeats and slow drift around the previous value.
  function automatic logic [SAMPLE_BITS-1:0] pick_value(logic [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_BITS'($urandom);
      4, 5:       return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
      6: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      7:       return prev;
      8:       return prev + SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
      default: return SAMPLE_BITS'($urandom_range(0, 255)) - SAMPLE_BITS'(128);
    endcase
  endfunction

  function automatic triple_t axes(logic [SAMPLE_BITS-1:0] x, logic [SAMPLE_BITS-1:0] y,
                                   logic [SAMPLE_BITS-1:0] z);
    return {z, y, x};
  endfunction

  // Offer one transaction after a random gap; return once ready is seen high after an edge.
  task automatic send_sample(triple_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.sample_x <= s[0];
    in_if.sample_y <= s[1];
    in_if.sample_z <= s[2];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    last_sample = s;
    sent++;
  endtask

  // Drop valid, wait for every owed median, then let the pipeline empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Setup cycle, then access cycle held until pready.
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: stall at random, with steady stretches of full acceptance.
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int phase;
    int n_items;
    logic [CFG_DATA_W-1:0] wdata;
    logic [SAMPLE_BITS-1:0] px;
    logic [SAMPLE_BITS-1:0] py;
    logic [SAMPLE_BITS-1:0] pz;

    sb             = new();
    steady         = 1'b0;
    sent           = 0;
    last_sample    = '0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    in_if.sample_z = '0;

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of five: extremes against the cleared history, bit
    // patterns that toggle every sample bit, equal values on all axes.
    send_sample(axes(16'h7FFF, 16'h8000, 16'h0000));
    send_sample(axes(16'h8000, 16'h7FFF, 16'hFFFF));
    send_sample(axes(16'h0001, 16'hFFFF, 16'h7FFF));
    send_sample(axes(16'h5555, 16'hAAAA, 16'h7FFF));
    send_sample(axes(16'hAAAA, 16'h5555, 16'h8000));
    send_sample(axes(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(axes(16'h0000, 16'h0000, 16'h0000));
    send_sample(axes(16'd100, 16'd100, -16'sd100));

    // Write to an unmapped index: window must stay at five.
    settle();
    cfg_write(ADDR_UNMAPPED, 32'h0000_0001);
    send_sample(axes(16'd7, 16'd7, 16'd7));
    send_sample(axes(-16'sd5, 16'd3, 16'd9));
    send_sample(axes(16'd2, -16'sd2, 16'd0));

    // Window of zero behaves as one: median is the new sample.
    settle();
    cfg_write(ADDR_WINDOW_SIZE, 32'h0000_0000);
    send_sample(axes(16'h1234, 16'h8001, 16'h7FFE));
    send_sample(axes(16'h8000, 16'h7FFF, 16'h0000));
    send_sample(axes(16'hFFFF, 16'h0001, 16'hC000));

    // All data bits set: window saturates at the maximum.
    settle();
    cfg_write(ADDR_WINDOW_SIZE, 32'hFFFF_FFFF);
    send_sample(axes(16'h7FFF, 16'h7FFF, 16'h8000));
    send_sample(axes(16'h7FFF, 16'h8000, 16'h8000));
    send_sample(axes(16'h0003, 16'hFFFD, 16'h0000));
    send_sample(axes(16'h4000, 16'hBFFF, 16'h0001));

    // Even window picks the upper median.
    settle();
    cfg_write(ADDR_WINDOW_SIZE, 32'd2);
    send_sample(axes(16'd10, -16'sd10, 16'd0));
    send_sample(axes(16'd20, -16'sd20, 16'd1));
    send_sample(axes(16'd10, -16'sd10, 16'd1));

    // Exact maximum window.
    settle();
    cfg_write(ADDR_WINDOW_SIZE, 32'd32);
    send_sample(axes(16'h8000, 16'h7FFF, 16'h0000));
    send_sample(axes(16'h0100, 16'hFF00, 16'h0010));
    send_sample(axes(16'hFFFE, 16'h0002, 16'hFFF0));

    // Random phases: a fresh window each phase, the boundary sizes first.
    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      settle();
      case (phase)
        0:       wdata = 32'd1;
        1:       wdata = 32'd33;
        2:       wdata = 32'd63;
        3:       wdata = 32'd31;
        4:       wdata = 32'd0;
        default: begin
          case ($urandom_range(0, 3))
            0, 1:    wdata = $urandom_range(1, WINDOW_MAX);
            2:       wdata = $urandom;
            default: wdata = $urandom_range(1, 8);
          endcase
        end
      endcase
      if ($urandom_range(0, 5) == 0) cfg_write(ADDR_UNMAPPED, $urandom);
      cfg_write(ADDR_WINDOW_SIZE, wdata);
      steady  = (phase % 5 == 3);
      n_items = $urandom_range(20, 40);
      for (int i = 0; i < n_items && sent < TOTAL_ITEMS; i++) begin
        px = pick_value(last_sample[0]);
        py = pick_value(last_sample[1]);
        pz = pick_value(last_sample[2]);
        send_sample(axes(px, py, pz));
      end
      phase++;
    end

    // Drain and let any stray result show up.
    steady = 1'b0;
    settle();

    $display("Sent %0d samples, checked %0d medians, %0d register writes", sb.n_samples,
             sb.n_medians, sb.n_writes);
    $display("Windows covered: zero, saturated, even and odd sizes, unmapped writes ignored");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/smf_pkg.sv
hw/rtl/smf_if.sv
hw/rtl/smf_cell.sv
hw/rtl/sliding_median_filter_3axis.sv
tb/testbench.sv
